// File: hdl/tpfb_pkg.sv
// Shared constants, codes and the per-byte color rule of the two plane frame buffer.
// No dependencies; the top and the testbench refer to it by scoped names.
`default_nettype none

package tpfb_pkg;

  // default panel geometry in pixels
  localparam int unsigned PanelWidthDef  = 128;
  localparam int unsigned PanelHeightDef = 296;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam int unsigned BitSelMask = 7;

  // operation codes
  localparam logic [1:0] FUNC_DRAW   = 2'd0;
  localparam logic [1:0] FUNC_FILL   = 2'd1;
  localparam logic [1:0] FUNC_INVERT = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // color codes
  localparam logic [2:0] COL_WHITE = 3'd0;
  localparam logic [2:0] COL_BLACK = 3'd1;
  localparam logic [2:0] COL_COLOR = 3'd2;
  localparam logic [2:0] COL_INV1  = 3'd3;
  localparam logic [2:0] COL_INV2  = 3'd4;
  localparam logic [2:0] COL_INV3  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_ROTATION  = 2'd0;
  localparam logic [1:0] REG_HAS_COLOR = 2'd1;

  // new logical {black, color} bytes after applying a color rule to the masked bits
  function automatic logic [15:0] apply_rule(input logic [2:0] col, input logic [7:0] b,
                                             input logic [7:0] c_raw, input logic [7:0] m,
                                             input logic hc);
    logic [7:0] c;
    logic [7:0] bn;
    logic [7:0] cn;
    c  = hc ? c_raw : 8'h00;
    bn = b;
    cn = c;
    case (col)
      COL_WHITE: begin
        bn = 8'h00;
        cn = 8'h00;
      end
      COL_BLACK: begin
        bn = BYTE_ONES;
        cn = 8'h00;
      end
      COL_COLOR: begin
        bn = 8'h00;
        cn = BYTE_ONES;
      end
      // clear color where set, else toggle black
      COL_INV1: begin
        bn = b ^ ~c;
        cn = 8'h00;
      end
      // color -> black -> color cycle, white -> black
      COL_INV2: begin
        bn = c | ~b;
        cn = ~c & b;
      end
      // color -> black -> white -> color (black when no color plane)
      COL_INV3: begin
        bn = c | (~b & {8{~hc}});
        cn = ~c & ~b & {8{hc}};
      end
      default: begin
        bn = b;
        cn = c;
      end
    endcase
    return {(b & ~m) | (bn & m), (c & ~m) | (cn & m)};
  endfunction

endpackage

`default_nettype wire

// File: hdl/tpfb_ram.sv
// Generic simple dual port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module tpfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4736
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/two_plane_pixel_frame_buffer_top.sv
// Two plane frame buffer: sequencer, address math and read-modify-write around two plane RAMs.
// Depends on tpfb_pkg and tpfb_ram.
//
//   channel | signals                                           | dir
//   in      | in_valid_i in_ready_o func_i pos_x_i pos_y_i       | in
//           | pixel_color_i byte_index_i                        |
//   out     | out_valid_o out_ready_i black_byte_o color_byte_o  | out
//           | applied_o                                         |
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i     | in
//
// One word at a time. A draw passes ADDR, PIX, DATA and FIN, a read ADDR, DATA and FIN, an
// invert with a color plane ADDR and FIN, and fills and inverts that walk the planes ADDR, WALK and FIN.
// The walk moves one byte per cycle through the single read-modify-write path of the RAMs.
// After reset a clearing pass writes white to both planes, one byte per cycle; no word is
// accepted until the pass ends, while config writes are taken.
// A result waiting in the output register does not block the next accept.
`default_nettype none

module two_plane_pixel_frame_buffer_top #(
  parameter int unsigned PANEL_WIDTH  = tpfb_pkg::PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = tpfb_pkg::PanelHeightDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [2:0]         pixel_color_i,
  input  wire logic [12:0]        byte_index_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              black_byte_o,
  output logic [7:0]              color_byte_o,
  output logic                    applied_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  localparam int unsigned PlaneBytes = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int unsigned Pixels     = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned AW         = $clog2(PlaneBytes);
  localparam int unsigned PW         = $clog2(Pixels);
  localparam int unsigned XW         = $clog2(PANEL_WIDTH);
  localparam int unsigned YW         = $clog2(PANEL_HEIGHT);
  localparam int unsigned LastByte   = (Pixels - 1) / 8;
  localparam int unsigned LastBits   = Pixels - LastByte * 8;
  localparam logic [7:0]  LastMask   = 8'(tpfb_pkg::BYTE_ONES << (8 - LastBits));

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_PIX   = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // control state
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] end_q, end_d;
  logic          iss_done_q, iss_done_d;
  logic          wv_q, wv_d;
  logic          walk_const_q, walk_const_d;
  logic [2:0]    op_col_q, op_col_d;
  logic          op_hc_q, op_hc_d;
  logic          swapped_q, swapped_d;
  logic [1:0]    rotation_q, rotation_d;
  logic          has_color_q, has_color_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [1:0]    func_q;
  logic [15:0]   x_q;
  logic [15:0]   y_q;
  logic [2:0]    col_q;
  logic [12:0]   bi_q;
  logic [XW-1:0] px_q, px_d;
  logic [YW-1:0] py_q, py_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    mask_q, mask_d;
  logic [AW-1:0] wa_q;
  logic [7:0]    res_b_q, res_b_d;
  logic [7:0]    res_c_q, res_c_d;
  logic          res_ap_q, res_ap_d;
  logic [7:0]    out_b_q;
  logic [7:0]    out_c_q;
  logic          out_ap_q;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic [7:0]    rd0, rd1;
  logic [7:0]    lb, lc;
  logic [15:0]   rule_out;
  logic          we0, we1;
  logic [7:0]    wd0, wd1;

  logic          in_acc;
  logic          out_load;
  logic [15:0]   rw, rh;
  logic [15:0]   pxf, pyf;
  logic          draw_ok;
  logic [PW-1:0] pix;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o  = out_valid_q;
  assign black_byte_o = out_b_q;
  assign color_byte_o = out_c_q;
  assign applied_o    = out_ap_q;

  // clip to the rotated size and map to panel coordinates
  always_comb begin
    rw = rotation_q[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    rh = rotation_q[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
    draw_ok = !x_q[15] && !y_q[15] && (x_q < rw) && (y_q < rh)
              && (col_q <= tpfb_pkg::COL_INV3);
    case (rotation_q)
      2'd1: begin
        pxf = 16'(PANEL_WIDTH - 1) - y_q;
        pyf = x_q;
      end
      2'd2: begin
        pxf = 16'(PANEL_WIDTH - 1) - x_q;
        pyf = 16'(PANEL_HEIGHT - 1) - y_q;
      end
      2'd3: begin
        pxf = y_q;
        pyf = 16'(PANEL_HEIGHT - 1) - x_q;
      end
      default: begin
        pxf = x_q;
        pyf = y_q;
      end
    endcase
    px_d = XW'(pxf);
    py_d = YW'(pyf);
  end

  // pixel number of the mapped point
  assign pix = PW'(py_q) * PW'(PANEL_WIDTH) + PW'(px_q);

  // read port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q;
    if (state_q == ST_PIX) begin
      rd_en   = 1'b1;
      rd_addr = AW'(pix >> 3);
    end else if (state_q == ST_ADDR) begin
      rd_en   = (func_q == tpfb_pkg::FUNC_READ);
      rd_addr = AW'(bi_q);
    end else if (state_q == ST_WALK || state_q == ST_CLEAR) begin
      rd_en   = !iss_done_q;
      rd_addr = cnt_q;
    end
  end

  // write port: single pixel write-back or walk stage
  always_comb begin
    if (state_q == ST_DATA) begin
      wr_en   = (func_q == tpfb_pkg::FUNC_DRAW);
      wr_addr = addr_q;
      wr_mask = mask_q;
    end else begin
      wr_en   = wv_q;
      wr_addr = wa_q;
      wr_mask = (!walk_const_q && wa_q == AW'(LastByte)) ? LastMask : tpfb_pkg::BYTE_ONES;
    end
  end

  // logical planes over the physical RAMs
  assign lb       = swapped_q ? rd1 : rd0;
  assign lc       = swapped_q ? rd0 : rd1;
  assign rule_out = tpfb_pkg::apply_rule(op_col_q, lb, lc, wr_mask, op_hc_q);
  assign we0      = wr_en && (!swapped_q || op_hc_q);
  assign we1      = wr_en && (swapped_q || op_hc_q);
  assign wd0      = swapped_q ? rule_out[7:0] : rule_out[15:8];
  assign wd1      = swapped_q ? rule_out[15:8] : rule_out[7:0];

  tpfb_ram #(
    .WIDTH (8),
    .DEPTH (PlaneBytes)
  ) u_black_ram (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wr_addr),
    .wdata_i (wd0),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd0)
  );

  tpfb_ram #(
    .WIDTH (8),
    .DEPTH (PlaneBytes)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wr_addr),
    .wdata_i (wd1),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd1)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    end_d        = end_q;
    iss_done_d   = iss_done_q;
    wv_d         = 1'b0;
    walk_const_d = walk_const_q;
    op_col_d     = op_col_q;
    op_hc_d      = op_hc_q;
    swapped_d    = swapped_q;
    addr_d       = addr_q;
    mask_d       = mask_q;
    res_b_d      = res_b_q;
    res_c_d      = res_c_q;
    res_ap_d     = res_ap_q;
    out_load     = 1'b0;
    unique case (state_q) inside
      ST_CLEAR, ST_WALK: begin
        if (!iss_done_q) begin
          cnt_d = cnt_q + AW'(1);
          wv_d  = 1'b1;
          if (cnt_q == end_q) begin
            iss_done_d = 1'b1;
          end
        end else if (!wv_q) begin
          state_d = (state_q == ST_CLEAR) ? ST_IDLE : ST_FIN;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_hc_d = has_color_q;
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        res_b_d      = 8'h00;
        res_c_d      = 8'h00;
        res_ap_d     = 1'b0;
        cnt_d        = '0;
        iss_done_d   = 1'b0;
        walk_const_d = 1'b0;
        end_d        = AW'(LastByte);
        op_col_d     = col_q;
        state_d      = ST_FIN;
        unique case (func_q)
          tpfb_pkg::FUNC_DRAW: begin
            if (draw_ok) begin
              res_ap_d = 1'b1;
              state_d  = ST_PIX;
            end
          end
          tpfb_pkg::FUNC_FILL: begin
            case (col_q) inside
              tpfb_pkg::COL_WHITE, tpfb_pkg::COL_BLACK, tpfb_pkg::COL_COLOR: begin
                walk_const_d = 1'b1;
                end_d        = AW'(PlaneBytes - 1);
                res_ap_d     = 1'b1;
                state_d      = ST_WALK;
              end
              tpfb_pkg::COL_INV1, tpfb_pkg::COL_INV2, tpfb_pkg::COL_INV3: begin
                res_ap_d = 1'b1;
                state_d  = ST_WALK;
              end
              default: begin
                res_ap_d = 1'b0;
              end
            endcase
          end
          tpfb_pkg::FUNC_INVERT: begin
            res_ap_d = 1'b1;
            if (op_hc_q) begin
              swapped_d = !swapped_q;
            end else begin
              op_col_d = tpfb_pkg::COL_INV1;
              state_d  = ST_WALK;
            end
          end
          tpfb_pkg::FUNC_READ: begin
            if (32'(bi_q) < PlaneBytes) begin
              res_ap_d = 1'b1;
              state_d  = ST_DATA;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_PIX: begin
        addr_d  = AW'(pix >> 3);
        mask_d  = 8'h80 >> (pix & PW'(tpfb_pkg::BitSelMask));
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (func_q == tpfb_pkg::FUNC_READ) begin
          res_b_d = lb;
          res_c_d = op_hc_q ? lc : 8'h00;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration registers
  always_comb begin
    rotation_d  = rotation_q;
    has_color_d = has_color_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tpfb_pkg::REG_ROTATION:  rotation_d  = cfg_data_i[1:0];
        tpfb_pkg::REG_HAS_COLOR: has_color_d = cfg_data_i[0];
        default: begin
          rotation_d = rotation_q;
        end
      endcase
    end
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      end_q        <= AW'(PlaneBytes - 1);
      iss_done_q   <= 1'b0;
      wv_q         <= 1'b0;
      walk_const_q <= 1'b1;
      op_col_q     <= tpfb_pkg::COL_WHITE;
      op_hc_q      <= 1'b1;
      swapped_q    <= 1'b0;
      rotation_q   <= 2'd0;
      has_color_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      end_q        <= end_d;
      iss_done_q   <= iss_done_d;
      wv_q         <= wv_d;
      walk_const_q <= walk_const_d;
      op_col_q     <= op_col_d;
      op_hc_q      <= op_hc_d;
      swapped_q    <= swapped_d;
      rotation_q   <= rotation_d;
      has_color_q  <= has_color_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      col_q  <= pixel_color_i;
      bi_q   <= byte_index_i;
    end
    if (state_q == ST_ADDR) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    addr_q   <= addr_d;
    mask_q   <= mask_d;
    wa_q     <= cnt_q;
    res_b_q  <= res_b_d;
    res_c_q  <= res_c_d;
    res_ap_q <= res_ap_d;
    if (out_load) begin
      out_b_q  <= res_b_q;
      out_c_q  <= res_c_q;
      out_ap_q <= res_ap_q;
    end
  end

  // the color plane of the logical view is never written while it is off
  a_color_off_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !op_hc_q) |-> (swapped_q ? !we0 : !we1))
    else $error("color plane written while turned off");

  // write-back uses data read in the previous cycle
  a_data_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> $past(rd_en))
    else $error("data stage without a preceding read");

  // walk writes stay inside the walked range
  a_walk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (wa_q <= end_q))
    else $error("walk write beyond its last byte");

  // no input word is taken while the planes are being walked
  a_walk_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wv_q || !iss_done_q && (state_q == ST_WALK || state_q == ST_CLEAR)) |-> !in_ready_o)
    else $error("input accepted during a plane walk");

endmodule

`default_nettype wire

// File: tb/sv/two_plane_pixel_frame_buffer_top_tb.sv
// Self-checking testbench for the two plane frame buffer: directed corner words, then random
// draw/read/fill/invert traffic under every rotation with the color plane on, and 0, 90 and 270 with it off.
// Depends on tpfb_pkg and the two_plane_pixel_frame_buffer_top RTL.
`default_nettype none

module two_plane_pixel_frame_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PanelW      = tpfb_pkg::PanelWidthDef;
  localparam int PanelH      = tpfb_pkg::PanelHeightDef;
  localparam int PlaneBytes  = PanelW * ((PanelH + 7) / 8);
  localparam int StallLimit  = 60000;
  localparam int ReportLimit = 10;

  // colors that neither draw nor fill
  localparam logic [2:0] COL_NOP_LO = 3'd6;
  localparam logic [2:0] COL_NOP_HI = 3'd7;

  typedef enum logic [1:0] {ROT_0, ROT_90, ROT_180, ROT_270} quarter_turn_e;

  typedef struct packed {
    logic [7:0] black;
    logic [7:0] color;
    logic       applied;
  } readout_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i        = tpfb_pkg::FUNC_DRAW;
  logic signed [15:0] pos_x_i       = '0;
  logic signed [15:0] pos_y_i       = '0;
  logic [2:0]         pixel_color_i = tpfb_pkg::COL_WHITE;
  logic [12:0]        byte_index_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [7:0]         black_byte_o;
  logic [7:0]         color_byte_o;
  logic               applied_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i   = tpfb_pkg::REG_ROTATION;
  logic [7:0]         cfg_data_i    = '0;

  two_plane_pixel_frame_buffer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pixel_color_i (pixel_color_i),
    .byte_index_i  (byte_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .black_byte_o  (black_byte_o),
    .color_byte_o  (color_byte_o),
    .applied_o     (applied_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the frame buffer and its settings
  logic [7:0]    black_mem [PlaneBytes] = '{default: 8'h00};
  logic [7:0]    color_mem [PlaneBytes] = '{default: 8'h00};
  bit            swapped_q       = 1'b0;
  quarter_turn_e rotation_q      = ROT_0;
  bit            color_on_q      = 1'b1;
  int            last_drawn_byte = 0;

  readout_t expected_readouts[$];
  int       mismatch_count  = 0;
  int       idle_cycles     = 0;
  bit       sender_gaps     = 1'b1;
  bit       receiver_stalls = 1'b1;

  // new {black, color} of one pixel under a color rule
  function automatic logic [1:0] recolor_pixel(logic [2:0] col, logic b, logic c);
    logic nb;
    logic nc;
    nb = b;
    nc = c;
    case (col)
      tpfb_pkg::COL_WHITE: begin
        nb = 1'b0;
        nc = 1'b0;
      end
      tpfb_pkg::COL_BLACK: begin
        nb = 1'b1;
        nc = 1'b0;
      end
      tpfb_pkg::COL_COLOR: begin
        nb = 1'b0;
        nc = 1'b1;
      end
      tpfb_pkg::COL_INV1: begin
        if (c) nc = 1'b0;
        else nb = !b;
      end
      tpfb_pkg::COL_INV2: begin
        if (c) begin
          nc = 1'b0;
          nb = 1'b1;
        end else if (b) begin
          nb = 1'b0;
          nc = 1'b1;
        end else begin
          nb = 1'b1;
        end
      end
      tpfb_pkg::COL_INV3: begin
        if (c) begin
          nc = 1'b0;
          nb = 1'b1;
        end else if (b) begin
          nb = 1'b0;
        end else if (color_on_q) begin
          nc = 1'b1;
        end else begin
          nb = 1'b1;
        end
      end
      default: ;
    endcase
    return {nb, nc};
  endfunction

  // apply a color rule to the masked pixels of one byte of the logical planes
  function automatic void paint_byte(int idx, logic [7:0] mask, logic [2:0] col);
    logic [7:0] lb;
    logic [7:0] lc;
    logic [1:0] bc;
    lb = swapped_q ? color_mem[idx] : black_mem[idx];
    lc = swapped_q ? black_mem[idx] : color_mem[idx];
    for (int k = 0; k < 8; k++) begin
      if (mask[k]) begin
        bc    = recolor_pixel(col, lb[k], color_on_q && lc[k]);
        lb[k] = bc[1];
        if (color_on_q) lc[k] = bc[0];
      end
    end
    if (swapped_q) begin
      color_mem[idx] = lb;
      black_mem[idx] = lc;
    end else begin
      black_mem[idx] = lb;
      color_mem[idx] = lc;
    end
  endfunction

  function automatic void paint_all(logic [2:0] col);
    for (int idx = 0; idx < PlaneBytes; idx++) paint_byte(idx, tpfb_pkg::BYTE_ONES, col);
  endfunction

  // update the shadow buffer for one request word and return the result word it gives
  function automatic readout_t predict_readout(logic [1:0] func, logic signed [15:0] pos_x,
                                               logic signed [15:0] pos_y, logic [2:0] col,
                                               logic [12:0] bi);
    readout_t r;
    int x;
    int y;
    int rw;
    int rh;
    int px;
    int py;
    int pix;
    logic [7:0] lb;
    logic [7:0] lc;
    r = '0;
    x = pos_x;
    y = pos_y;
    case (func)
      tpfb_pkg::FUNC_DRAW: begin
        rw = rotation_q[0] ? PanelH : PanelW;
        rh = rotation_q[0] ? PanelW : PanelH;
        if (col <= tpfb_pkg::COL_INV3 && x >= 0 && x < rw && y >= 0 && y < rh) begin
          case (rotation_q)
            ROT_90: begin
              px = PanelW - 1 - y;
              py = x;
            end
            ROT_180: begin
              px = PanelW - 1 - x;
              py = PanelH - 1 - y;
            end
            ROT_270: begin
              px = y;
              py = PanelH - 1 - x;
            end
            default: begin
              px = x;
              py = y;
            end
          endcase
          pix = py * PanelW + px;
          last_drawn_byte = pix >> 3;
          paint_byte(pix >> 3, 8'h80 >> (pix & 7), col);
          r.applied = 1'b1;
        end
      end
      tpfb_pkg::FUNC_FILL: begin
        if (col <= tpfb_pkg::COL_COLOR) begin
          lb = (col == tpfb_pkg::COL_BLACK) ? tpfb_pkg::BYTE_ONES : 8'h00;
          lc = (col == tpfb_pkg::COL_COLOR) ? tpfb_pkg::BYTE_ONES : 8'h00;
          for (int idx = 0; idx < PlaneBytes; idx++) begin
            if (swapped_q) color_mem[idx] = lb;
            else black_mem[idx] = lb;
            if (color_on_q) begin
              if (swapped_q) black_mem[idx] = lc;
              else color_mem[idx] = lc;
            end
          end
          r.applied = 1'b1;
        end else if (col <= tpfb_pkg::COL_INV3) begin
          paint_all(col);
          r.applied = 1'b1;
        end
      end
      tpfb_pkg::FUNC_INVERT: begin
        if (color_on_q) swapped_q = !swapped_q;
        else paint_all(tpfb_pkg::COL_INV1);
        r.applied = 1'b1;
      end
      default: begin
        if (bi < PlaneBytes) begin
          r.black   = swapped_q ? color_mem[bi] : black_mem[bi];
          r.color   = !color_on_q ? 8'h00 : (swapped_q ? black_mem[bi] : color_mem[bi]);
          r.applied = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // offer one request word, with an occasional gap before it
  task automatic send_request(logic [1:0] func, logic signed [15:0] px, logic signed [15:0] py,
                              logic [2:0] col, logic [12:0] bi);
    if (sender_gaps && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    pos_x_i       <= px;
    pos_y_i       <= py;
    pixel_color_i <= col;
    byte_index_i  <= bi;
    expected_readouts.push_back(predict_readout(func, px, py, col, bi));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tpfb_pkg::REG_ROTATION:  rotation_q = quarter_turn_e'(data[1:0]);
      tpfb_pkg::REG_HAS_COLOR: color_on_q = data[0];
      default: ;
    endcase
  endtask

  // upper data bits are random, the block only keeps the low ones
  task automatic write_config(quarter_turn_e rot, bit hc);
    write_register(tpfb_pkg::REG_ROTATION, {6'($urandom), rot});
    write_register(tpfb_pkg::REG_HAS_COLOR, {7'($urandom), hc});
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering words until every result word is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk_i);
  endtask

  // reset contents, clipping edges, ignored colors, every rule, fills, swaps and reads
  task automatic test_directed_corners();
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd0);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd4735);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd4736);
    send_request(tpfb_pkg::FUNC_READ,   -16'sd1,   -16'sd1,   COL_NOP_HI,          13'h1FFF);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd0,    16'sd0,    tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd127,  16'sd295,  tpfb_pkg::COL_COLOR, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   -16'sd1,   16'sd0,    tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd128,  16'sd0,    tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd0,    16'sd296,  tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sh7FFF, 16'sh8000, tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd1,    16'sd0,    COL_NOP_LO,          13'd0);
    send_request(tpfb_pkg::FUNC_FILL,   16'sd0,    16'sd0,    COL_NOP_HI,          13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd0,    16'sd0,    tpfb_pkg::COL_INV1,  13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd127,  16'sd295,  tpfb_pkg::COL_INV2,  13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd127,  16'sd295,  tpfb_pkg::COL_INV3,  13'd0);
    send_request(tpfb_pkg::FUNC_DRAW,   16'sd5,    16'sd5,    tpfb_pkg::COL_INV3,  13'd0);
    send_request(tpfb_pkg::FUNC_INVERT, 16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd0);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd80);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd4735);
    send_request(tpfb_pkg::FUNC_FILL,   16'sd0,    16'sd0,    tpfb_pkg::COL_BLACK, 13'd0);
    send_request(tpfb_pkg::FUNC_FILL,   16'sd0,    16'sd0,    tpfb_pkg::COL_INV2,  13'd0);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd100);
    send_request(tpfb_pkg::FUNC_INVERT, 16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd0);
    send_request(tpfb_pkg::FUNC_FILL,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd0);
    send_request(tpfb_pkg::FUNC_READ,   16'sd0,    16'sd0,    tpfb_pkg::COL_WHITE, 13'd0);
  endtask

  // random words under one setting; draws cluster in a small window that reads revisit
  task automatic test_random_traffic(quarter_turn_e rot, bit hc, int count, bit calm);
    int rw;
    int rh;
    int hot_x;
    int hot_y;
    int r;
    int x;
    int y;
    logic [1:0]  func;
    logic [2:0]  col;
    logic [12:0] bi;
    wait_drained();
    write_config(rot, hc);
    sender_gaps     = !calm;
    receiver_stalls = !calm;
    rw    = rot[0] ? PanelH : PanelW;
    rh    = rot[0] ? PanelW : PanelH;
    hot_x = $urandom_range(rw - 16);
    hot_y = $urandom_range(rh - 16);
    repeat (count) begin
      x   = $urandom;
      y   = $urandom;
      col = 3'($urandom_range(7));
      bi  = 13'($urandom_range(13'h1FFF));
      r   = $urandom_range(99);
      if (r < 58) begin
        func = tpfb_pkg::FUNC_DRAW;
        col  = ($urandom_range(99) < 92) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
        r    = $urandom_range(99);
        if (r < 70) begin
          x = hot_x + $urandom_range(15);
          y = hot_y + $urandom_range(15);
        end else if (r < 85) begin
          x = $urandom_range(rw - 1);
          y = $urandom_range(rh - 1);
        end else if (r < 93) begin
          case ($urandom_range(3))
            0: x = -1;
            1: x = 0;
            2: x = rw - 1;
            default: x = rw;
          endcase
          case ($urandom_range(3))
            0: y = -1;
            1: y = 0;
            2: y = rh - 1;
            default: y = rh;
          endcase
        end
      end else if (r < 92) begin
        func = tpfb_pkg::FUNC_READ;
        r    = $urandom_range(99);
        if (r < 50) bi = 13'(last_drawn_byte);
        else if (r < 90) bi = 13'($urandom_range(PlaneBytes - 1));
        else bi = 13'($urandom_range(13'h1FFF, PlaneBytes));
      end else if (r < 96) begin
        func = tpfb_pkg::FUNC_FILL;
      end else begin
        func = tpfb_pkg::FUNC_INVERT;
      end
      send_request(func, x[15:0], y[15:0], col, bi);
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= !(receiver_stalls && $urandom_range(99) < 6);
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin : check_result
    readout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readouts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: unexpected result word black %02h color %02h applied %0b",
                   $time, black_byte_o, color_byte_o, applied_o);
      end else begin
        want = expected_readouts.pop_front();
        if (black_byte_o !== want.black || color_byte_o !== want.color ||
            applied_o !== want.applied) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: mismatch black exp %02h got %02h, color exp %02h got %02h, %s%0b got %0b",
                     $time, want.black, black_byte_o, want.color, color_byte_o,
                     "applied exp ", want.applied, applied_o);
        end
      end
    end
  end

  // give up when no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_random_traffic(ROT_0,   1'b1, 105, 1'b0);
    test_random_traffic(ROT_90,  1'b1, 105, 1'b1);
    test_random_traffic(ROT_180, 1'b1, 105, 1'b0);
    test_random_traffic(ROT_270, 1'b1, 105, 1'b0);
    test_random_traffic(ROT_0,   1'b0, 105, 1'b0);
    test_random_traffic(ROT_90,  1'b0, 105, 1'b0);
    test_random_traffic(ROT_270, 1'b0, 105, 1'b0);
    test_random_traffic(ROT_180, 1'b1, 105, 1'b0);
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_readouts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
